@@ sv/triangle_plane_split_macros.svh @@
// ----------------------------------------------------------------------------
// triangle_plane_split assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_SPLIT_MACROS_SVH
`define TRIANGLE_PLANE_SPLIT_MACROS_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg
// widths, codes and helper types for the triangle plane splitter
// ----------------------------------------------------------------------------
package tps_pkg;

	// datapath widths
	localparam int COORD_W   = 32;
	localparam int NORM_W    = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = NORM_W + DIFF_W;
	localparam int DIST_W    = PROD_W + 2;
	localparam int MAG_W     = DIST_W;
	localparam int REM_W     = MAG_W + 1;
	localparam int FRAC_BITS = 30;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int MULC_W    = DIFF_W + FRAC_W;
	localparam int CUT_LAT   = DIV_STEPS + 2;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// result kinds
	localparam logic [1:0] KIND_POS = 2'd0;
	localparam logic [1:0] KIND_NEG = 2'd1;
	localparam logic [1:0] KIND_SEG = 2'd2;

	// register indexes
	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_POINT_X  = 3'd3;
	localparam logic [2:0] REG_POINT_Y  = 3'd4;
	localparam logic [2:0] REG_POINT_Z  = 3'd5;

	localparam logic [NORM_W-1:0] NORMAL_Z_RESET = 16'd16384;

	// point of a triangle, index 0 is x
	typedef logic [2:0][COORD_W-1:0] vec_t;
	// difference vector, signed per component
	typedef logic [2:0][DIFF_W-1:0] dvec_t;

	// which point a result corner takes
	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_T,
		SEL_V1,
		SEL_V2,
		SEL_C1,
		SEL_C2
	} sel_t;

	// order of vertices: lone vertex first
	typedef enum logic [1:0] {
		ROT_ABC,
		ROT_CAB,
		ROT_BCA
	} rot_t;

	typedef struct packed {
		logic [1:0] kind;
		sel_t       p1;
		sel_t       p2;
		sel_t       p3;
	} slot_t;

	// result list for one triangle, lst is the index of the final result
	typedef struct packed {
		logic [1:0]      lst;
		slot_t [3:0]     slots;
	} plan_t;

	function automatic slot_t mk_slot(logic [1:0] kind, sel_t a, sel_t b, sel_t c);
		slot_t s;
		s.kind = kind;
		s.p1   = a;
		s.p2   = b;
		s.p3   = c;
		return s;
	endfunction

endpackage

@@ sv/tps_chan_if.sv @@
// ----------------------------------------------------------------------------
// tps channel interfaces
// triangle input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tps_tri_if import tps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_a_x;
	logic signed [COORD_W-1:0] vertex_a_y;
	logic signed [COORD_W-1:0] vertex_a_z;
	logic signed [COORD_W-1:0] vertex_b_x;
	logic signed [COORD_W-1:0] vertex_b_y;
	logic signed [COORD_W-1:0] vertex_b_z;
	logic signed [COORD_W-1:0] vertex_c_x;
	logic signed [COORD_W-1:0] vertex_c_y;
	logic signed [COORD_W-1:0] vertex_c_z;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		       vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		       vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		output ready
	);
endinterface

interface tps_res_if import tps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                item_kind;
	logic signed [COORD_W-1:0] point_one_x;
	logic signed [COORD_W-1:0] point_one_y;
	logic signed [COORD_W-1:0] point_one_z;
	logic signed [COORD_W-1:0] point_two_x;
	logic signed [COORD_W-1:0] point_two_y;
	logic signed [COORD_W-1:0] point_two_z;
	logic signed [COORD_W-1:0] point_three_x;
	logic signed [COORD_W-1:0] point_three_y;
	logic signed [COORD_W-1:0] point_three_z;
	logic                      last_of_run;

	modport source (
		output valid, item_kind, point_one_x, point_one_y, point_one_z, point_two_x,
		       point_two_y, point_two_z, point_three_x, point_three_y, point_three_z,
		       last_of_run,
		input  ready
	);
	modport sink (
		input  valid, item_kind, point_one_x, point_one_y, point_one_z, point_two_x,
		       point_two_y, point_two_z, point_three_x, point_three_y, point_three_z,
		       last_of_run,
		output ready
	);
endinterface

@@ sv/tps_cut_unit.sv @@
// ----------------------------------------------------------------------------
// tps_cut_unit
// pipelined cut point: restoring divide one bit per stage, then scale and add
// ----------------------------------------------------------------------------
module tps_cut_unit import tps_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [MAG_W-1:0] num,
	input  logic [MAG_W-1:0] den,
	input  vec_t             base,
	input  dvec_t            diff,
	output vec_t             cut
);

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [MAG_W-1:0]     den;
		logic [DIV_STEPS-1:0] quo;
		vec_t                 base;
		dvec_t                diff;
	} div_t;

	div_t div_s [DIV_STEPS];
	div_t div_src [DIV_STEPS];

	logic [2:0][MULC_W-1:0] prod_s;
	logic [2:0]             neg_s;
	vec_t                   base_s;
	vec_t                   cut_s;

	// one quotient bit
	function automatic div_t div_step(div_t a);
		div_t             o;
		logic [REM_W-1:0] r2;
		logic             ge;
		o  = a;
		r2 = {a.rem[REM_W-2:0], 1'b0};
		ge = r2 >= REM_W'(a.den);
		o.rem = ge ? (r2 - REM_W'(a.den)) : r2;
		o.quo = {a.quo[DIV_STEPS-2:0], ge};
		return o;
	endfunction

	// divider stages
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		if (j == 0) begin : g_first
			always_comb begin
				div_src[j].rem  = REM_W'(num);
				div_src[j].den  = den;
				div_src[j].quo  = '0;
				div_src[j].base = base;
				div_src[j].diff = diff;
			end
		end else begin : g_next
			assign div_src[j] = div_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= div_step(div_src[j]);
			end
		end
	end

	// round fraction to q30 and scale the edge vector
	always_ff @(posedge clk) begin
		logic [FRAC_W-1:0] frac;
		logic [DIFF_W-1:0] mag;
		if (en) begin
			// one spare bit so an all-ones quotient rounds up to one
			frac = FRAC_W'(({1'b0, div_s[DIV_STEPS-1].quo} + (DIV_STEPS+1)'(1)) >> 1);
			for (int k = 0; k < 3; k++) begin
				mag = div_s[DIV_STEPS-1].diff[k][DIFF_W-1] ?
					(~div_s[DIV_STEPS-1].diff[k] + 1'b1) : div_s[DIV_STEPS-1].diff[k];
				prod_s[k] <= MULC_W'(mag) * MULC_W'(frac);
				neg_s[k]  <= div_s[DIV_STEPS-1].diff[k][DIFF_W-1];
			end
			base_s <= div_s[DIV_STEPS-1].base;
		end
	end

	// round half away from zero and offset from the lone vertex
	always_ff @(posedge clk) begin
		logic [MULC_W-1:0]           rnd;
		logic [MULC_W-FRAC_BITS-1:0] step;
		logic [MULC_W-FRAC_BITS-1:0] b;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rnd  = prod_s[k] + (MULC_W'(1) << (FRAC_BITS - 1));
				step = rnd[MULC_W-1:FRAC_BITS];
				b    = (MULC_W-FRAC_BITS)'(signed'(base_s[k]));
				cut_s[k] <= neg_s[k] ? COORD_W'(b - step) : COORD_W'(b + step);
			end
		end
	end

	assign cut = cut_s;

endmodule

@@ sv/triangle_plane_split.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_split
// splits a triangle against a configured plane into side-tagged triangles
// and the directed cut segment
// ----------------------------------------------------------------------------
// channel   | dir | handshake      | item
// triangle  | in  | valid/ready    | three Q16.16 vertices
// result    | out | valid/ready    | kind, up to three points, last_of_run
// apb       | in  | psel/penable   | plane normal and plane point registers
//
// results leave one per cycle while the result port is ready; a triangle
// gives 0 to 4 results; a new triangle enters whenever the emit stage frees up
// the cut divider is 31 pipeline stages, one quotient bit each
// reset clears valid bits and point registers, normal to +z; no clearing pass
// a stalled result port holds every stage in place
// ----------------------------------------------------------------------------
`include "triangle_plane_split_macros.svh"

module triangle_plane_split import tps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tps_tri_if.sink           triangle,
	tps_res_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef struct packed {
		plan_t plan;
		vec_t  tv;
		vec_t  v1;
		vec_t  v2;
	} dly_t;

	typedef struct packed {
		plan_t plan;
		vec_t  tv;
		vec_t  v1;
		vec_t  v2;
		vec_t  c1;
		vec_t  c2;
	} emit_t;

	logic [2:0][NORM_W-1:0]  nrm_q;
	logic [2:0][COORD_W-1:0] pnt_q;

	logic                   en;
	logic                   wr_en;

	vec_t                   vin [3];
	logic                   vld_s1;
	vec_t                   vtx_s1 [3];
	dvec_t                  pd_s1 [3];
	logic                   vld_s2;
	vec_t                   vtx_s2 [3];
	logic [2:0][PROD_W-1:0] prod_s2 [3];
	logic                   vld_s3;
	vec_t                   vtx_s3 [3];
	logic [DIST_W-1:0]      dist_s3 [3];

	logic [2:0]             pos;
	logic [2:0]             neg;
	logic [2:0]             zer;
	logic [MAG_W-1:0]       mag [3];
	rot_t                   rot;
	logic                   keep;
	plan_t                  plan;
	vec_t                   tv_c, v1_c, v2_c;
	logic [MAG_W-1:0]       mt_c, m1_c, m2_c;
	logic                   pv, nv, zv, p1, n1, z1, p2, n2, z2;
	logic                   side_pos;

	logic                   vld_s4;
	plan_t                  plan_s4;
	vec_t                   tv_s4, v1_s4, v2_s4;
	logic [MAG_W-1:0]       mt_s4, m1_s4, m2_s4;

	logic                   vld_s5;
	plan_t                  plan_s5;
	vec_t                   tv_s5, v1_s5, v2_s5;
	logic [MAG_W-1:0]       num_s5, den1_s5, den2_s5;
	dvec_t                  df1_s5, df2_s5;

	logic                   dvld_s [CUT_LAT];
	dly_t                   dly_s [CUT_LAT];
	vec_t                   c1, c2;

	logic                   em_vld_q;
	emit_t                  em_q;
	logic [1:0]             idx_q;
	slot_t                  cur;
	logic                   last;

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q <= {NORMAL_Z_RESET, NORM_W'(0), NORM_W'(0)};
			pnt_q <= '0;
		end else if (wr_en) begin
			case (paddr[ADDR_W-1:2])
				REG_NORMAL_X: nrm_q[0] <= pwdata[NORM_W-1:0];
				REG_NORMAL_Y: nrm_q[1] <= pwdata[NORM_W-1:0];
				REG_NORMAL_Z: nrm_q[2] <= pwdata[NORM_W-1:0];
				REG_POINT_X:  pnt_q[0] <= pwdata;
				REG_POINT_Y:  pnt_q[1] <= pwdata;
				REG_POINT_Z:  pnt_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_NORMAL_X: prdata = DATA_W'(nrm_q[0]);
			REG_NORMAL_Y: prdata = DATA_W'(nrm_q[1]);
			REG_NORMAL_Z: prdata = DATA_W'(nrm_q[2]);
			REG_POINT_X:  prdata = pnt_q[0];
			REG_POINT_Y:  prdata = pnt_q[1];
			REG_POINT_Z:  prdata = pnt_q[2];
			default:      prdata = '0;
		endcase
	end

	// pipeline advances whenever the emit stage can take a new item
	assign last           = (idx_q == em_q.plan.lst);
	assign en             = !em_vld_q || (result.ready && last);
	assign triangle.ready = en;

	// stage 1: vertex minus plane point
	always_comb begin
		vin[0] = {triangle.vertex_a_z, triangle.vertex_a_y, triangle.vertex_a_x};
		vin[1] = {triangle.vertex_b_z, triangle.vertex_b_y, triangle.vertex_b_x};
		vin[2] = {triangle.vertex_c_z, triangle.vertex_c_y, triangle.vertex_c_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= triangle.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3 && keep;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vtx_s1[i] <= vin[i];
				for (int k = 0; k < 3; k++) begin
					pd_s1[i][k] <= {vin[i][k][COORD_W-1], vin[i][k]} -
						{pnt_q[k][COORD_W-1], pnt_q[k]};
				end
			end
		end
	end

	// stage 2: normal times offset, per component
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vtx_s2[i] <= vtx_s1[i];
				for (int k = 0; k < 3; k++) begin
					prod_s2[i][k] <= PROD_W'(signed'(nrm_q[k])) *
						PROD_W'(signed'(pd_s1[i][k]));
				end
			end
		end
	end

	// stage 3: signed distances
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vtx_s3[i]  <= vtx_s2[i];
				dist_s3[i] <= DIST_W'(signed'(prod_s2[i][0])) +
					DIST_W'(signed'(prod_s2[i][1])) + DIST_W'(signed'(prod_s2[i][2]));
			end
		end
	end

	// stage 4: side classes, lone vertex choice and result list
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i] = dist_s3[i][DIST_W-1];
			zer[i] = (dist_s3[i] == '0);
			pos[i] = !neg[i] && !zer[i];
			mag[i] = neg[i] ? (~dist_s3[i] + 1'b1) : dist_s3[i];
		end

		keep = 1'b1;
		if (!(zer[0] && zer[1] && zer[2]) &&
		    !((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
		    (!((pos[1] && pos[2]) || (neg[1] && neg[2])) ||
		     !((pos[0] && pos[2]) || (neg[0] && neg[2])))) begin
			rot = ROT_CAB;
		end else if (((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
		             !((pos[1] && pos[2]) || (neg[1] && neg[2]))) begin
			rot = ROT_BCA;
		end else begin
			rot = ROT_ABC;
		end

		case (rot)
			ROT_CAB: begin
				tv_c = vtx_s3[2]; v1_c = vtx_s3[0]; v2_c = vtx_s3[1];
				mt_c = mag[2];    m1_c = mag[0];    m2_c = mag[1];
				pv = pos[2]; nv = neg[2]; zv = zer[2];
				p1 = pos[0]; n1 = neg[0]; z1 = zer[0];
				p2 = pos[1]; n2 = neg[1]; z2 = zer[1];
			end
			ROT_BCA: begin
				tv_c = vtx_s3[1]; v1_c = vtx_s3[2]; v2_c = vtx_s3[0];
				mt_c = mag[1];    m1_c = mag[2];    m2_c = mag[0];
				pv = pos[1]; nv = neg[1]; zv = zer[1];
				p1 = pos[2]; n1 = neg[2]; z1 = zer[2];
				p2 = pos[0]; n2 = neg[0]; z2 = zer[0];
			end
			default: begin
				tv_c = vtx_s3[0]; v1_c = vtx_s3[1]; v2_c = vtx_s3[2];
				mt_c = mag[0];    m1_c = mag[1];    m2_c = mag[2];
				pv = pos[0]; nv = neg[0]; zv = zer[0];
				p1 = pos[1]; n1 = neg[1]; z1 = zer[1];
				p2 = pos[2]; n2 = neg[2]; z2 = zer[2];
			end
		endcase

		plan     = '0;
		side_pos = 1'b0;
		if (pos[0] && pos[1] && pos[2]) begin
			plan.slots[0] = mk_slot(KIND_POS, SEL_T, SEL_V1, SEL_V2);
		end else if (neg[0] && neg[1] && neg[2]) begin
			plan.slots[0] = mk_slot(KIND_NEG, SEL_T, SEL_V1, SEL_V2);
		end else if (zer[0] && zer[1] && zer[2]) begin
			// triangle in the plane gives nothing
			keep = 1'b0;
		end else if (z1 && z2) begin
			// edge in the plane, triangle follows the lone vertex
			plan.lst = 2'd1;
			if (!nv) begin
				plan.slots[0] = mk_slot(KIND_POS, SEL_T, SEL_V1, SEL_V2);
				plan.slots[1] = mk_slot(KIND_SEG, SEL_V1, SEL_V2, SEL_ZERO);
			end else begin
				plan.slots[0] = mk_slot(KIND_NEG, SEL_T, SEL_V1, SEL_V2);
				plan.slots[1] = mk_slot(KIND_SEG, SEL_V2, SEL_V1, SEL_ZERO);
			end
		end else if (z1 && !((pv && n2) || (nv && p2))) begin
			side_pos      = pv || (zv && p2);
			plan.lst      = zv ? 2'd1 : 2'd0;
			plan.slots[0] = mk_slot(side_pos ? KIND_POS : KIND_NEG, SEL_T, SEL_V1, SEL_V2);
			plan.slots[1] = side_pos ? mk_slot(KIND_SEG, SEL_T, SEL_V1, SEL_ZERO) :
				mk_slot(KIND_SEG, SEL_V1, SEL_T, SEL_ZERO);
		end else if (z2 && !((pv && n1) || (nv && p1))) begin
			side_pos      = pv || (zv && p1);
			plan.lst      = zv ? 2'd1 : 2'd0;
			plan.slots[0] = mk_slot(side_pos ? KIND_POS : KIND_NEG, SEL_T, SEL_V1, SEL_V2);
			plan.slots[1] = side_pos ? mk_slot(KIND_SEG, SEL_V2, SEL_T, SEL_ZERO) :
				mk_slot(KIND_SEG, SEL_T, SEL_V2, SEL_ZERO);
		end else if (zv) begin
			// lone vertex on the plane, others on one side
			plan.slots[0] = mk_slot(p1 ? KIND_POS : KIND_NEG, SEL_T, SEL_V1, SEL_V2);
		end else begin
			// true crossing: three pieces and the segment
			plan.lst      = 2'd3;
			plan.slots[0] = mk_slot(pv ? KIND_POS : KIND_NEG, SEL_T, SEL_C1, SEL_C2);
			plan.slots[1] = mk_slot(pv ? KIND_NEG : KIND_POS, SEL_C2, SEL_C1, SEL_V2);
			plan.slots[2] = mk_slot(pv ? KIND_NEG : KIND_POS, SEL_C1, SEL_V1, SEL_V2);
			plan.slots[3] = pv ? mk_slot(KIND_SEG, SEL_C1, SEL_C2, SEL_ZERO) :
				mk_slot(KIND_SEG, SEL_C2, SEL_C1, SEL_ZERO);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plan_s4 <= plan;
			tv_s4   <= tv_c;
			v1_s4   <= v1_c;
			v2_s4   <= v2_c;
			mt_s4   <= mt_c;
			m1_s4   <= m1_c;
			m2_s4   <= m2_c;
		end
	end

	// stage 5: divisor sums and edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			plan_s5 <= plan_s4;
			tv_s5   <= tv_s4;
			v1_s5   <= v1_s4;
			v2_s5   <= v2_s4;
			num_s5  <= mt_s4;
			den1_s5 <= mt_s4 + m1_s4;
			den2_s5 <= mt_s4 + m2_s4;
			for (int k = 0; k < 3; k++) begin
				df1_s5[k] <= {v1_s4[k][COORD_W-1], v1_s4[k]} - {tv_s4[k][COORD_W-1], tv_s4[k]};
				df2_s5[k] <= {v2_s4[k][COORD_W-1], v2_s4[k]} - {tv_s4[k][COORD_W-1], tv_s4[k]};
			end
		end
	end

	// cut points on both edges from the lone vertex
	tps_cut_unit u_cut1 (
		.clk  (clk),
		.en   (en),
		.num  (num_s5),
		.den  (den1_s5),
		.base (tv_s5),
		.diff (df1_s5),
		.cut  (c1)
	);

	tps_cut_unit u_cut2 (
		.clk  (clk),
		.en   (en),
		.num  (num_s5),
		.den  (den2_s5),
		.base (tv_s5),
		.diff (df2_s5),
		.cut  (c2)
	);

	// matching delay for the rest of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CUT_LAT; j++) begin
				dvld_s[j] <= 1'b0;
			end
		end else if (en) begin
			dvld_s[0] <= vld_s5;
			for (int j = 1; j < CUT_LAT; j++) begin
				dvld_s[j] <= dvld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= '{plan: plan_s5, tv: tv_s5, v1: v1_s5, v2: v2_s5};
			for (int j = 1; j < CUT_LAT; j++) begin
				dly_s[j] <= dly_s[j-1];
			end
		end
	end

	// emit stage: hands out the results of one item, one per cycle while the result port is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_vld_q <= 1'b0;
			idx_q    <= '0;
		end else if (en) begin
			em_vld_q <= dvld_s[CUT_LAT-1];
			idx_q    <= '0;
		end else if (result.ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			em_q.plan <= dly_s[CUT_LAT-1].plan;
			em_q.tv   <= dly_s[CUT_LAT-1].tv;
			em_q.v1   <= dly_s[CUT_LAT-1].v1;
			em_q.v2   <= dly_s[CUT_LAT-1].v2;
			em_q.c1   <= c1;
			em_q.c2   <= c2;
		end
	end

	function automatic vec_t pick(sel_t s, emit_t e);
		case (s)
			SEL_T:   return e.tv;
			SEL_V1:  return e.v1;
			SEL_V2:  return e.v2;
			SEL_C1:  return e.c1;
			SEL_C2:  return e.c2;
			default: return '0;
		endcase
	endfunction

	always_comb begin
		vec_t a, b, c;
		cur = em_q.plan.slots[idx_q];
		a   = pick(cur.p1, em_q);
		b   = pick(cur.p2, em_q);
		c   = pick(cur.p3, em_q);
		result.valid         = em_vld_q;
		result.item_kind     = cur.kind;
		result.point_one_x   = a[0];
		result.point_one_y   = a[1];
		result.point_one_z   = a[2];
		result.point_two_x   = b[0];
		result.point_two_y   = b[1];
		result.point_two_z   = b[2];
		result.point_three_x = c[0];
		result.point_three_y = c[1];
		result.point_three_z = c[2];
		result.last_of_run   = last;
	end

	// checks
	`TPS_ASSERT_NXT(a_run_continues, result.valid && result.ready && !result.last_of_run, result.valid && (idx_q == ($past(idx_q) + 2'd1)), "run ended before its last result")
	`TPS_ASSERT_NOW(a_idx_in_run, em_vld_q, idx_q <= em_q.plan.lst, "result index past end of run")
	`TPS_ASSERT_NOW(a_kind_known, result.valid, (result.item_kind == KIND_POS) || (result.item_kind == KIND_NEG) || (result.item_kind == KIND_SEG), "unknown result kind")
	`TPS_ASSERT_NOW(a_accept_frees, triangle.valid && triangle.ready, !em_vld_q || (result.ready && result.last_of_run), "item accepted while emit stage busy")

endmodule
